// ----- src/sijm_pkg.sv -----
// Shared types and constants for the sample interval jitter monitor.
// Holds the phase and item codes, register indexes and the controller/datapath structs.
// Depends on nothing; every other file refers to it by scoped names.
package sijm_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int INTERVAL_BITS_DEF = 32;

  localparam logic [15:0] RESET_SAMPLE_PERIOD = 16'd1;
  localparam logic [31:0] RESET_SETTLE_TIME   = 32'd2000;
  localparam logic [31:0] RESET_STOP_TIME     = 32'd2000;
  localparam logic [31:0] ALL_ONES32          = 32'hFFFF_FFFF;

  // Divider geometry: magnitude of the numerator and width of the running count.
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 32;

  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_SETTLE_TIME   = 2'd1;
  localparam logic [1:0] REG_STOP_TIME     = 2'd2;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_STOP   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_SETTLE    = 2'd1,
    PH_MEASURE   = 2'd2,
    PH_STOP_WAIT = 2'd3
  } phase_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic set_stop;
    logic prep;
    logic count;
    logic mul;
    logic check;
    logic acc;
    logic div_start;
    logic mean;
    logic dev_prep;
    logic dev;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   div_done;
  } status_t;

endpackage

// ----- src/sijm_div.sv -----
// Iterative unsigned divider for the jitter monitor, two quotient bits per cycle.
// Used by sijm_datapath; takes its widths from sijm_pkg.
module sijm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sijm_pkg::DIV_NUM_W-1:0] numer,
  input  logic [sijm_pkg::DIV_DEN_W-1:0] denom,
  output logic                           done,
  output logic [sijm_pkg::DIV_NUM_W-1:0] quot
);

  localparam int NW    = sijm_pkg::DIV_NUM_W;
  localparam int DW    = sijm_pkg::DIV_DEN_W;
  localparam int STEPS = NW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;

  logic [DW:0]   r1, r2, sub1, sub2;
  logic          ge1, ge2;
  logic [DW-1:0] rem1, rem2;

  // The numerator shifts out at the top while quotient bits shift in below.
  always_comb begin
    r1   = {rem, num[NW-1]};
    sub1 = r1 - {1'b0, den};
    ge1  = (r1 >= {1'b0, den});
    rem1 = ge1 ? sub1[DW-1:0] : r1[DW-1:0];
    r2   = {rem1, num[NW-2]};
    sub2 = r2 - {1'b0, den};
    ge2  = (r2 >= {1'b0, den});
    rem2 = ge2 ? sub2[DW-1:0] : r2[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      num <= {num[NW-3:0], ge1, ge2};
      rem <= rem2;
    end
  end

  assign quot = num;

endmodule

// ----- src/sijm_ctrl.sv -----
// Sequencer of the jitter monitor: walks each word through its steps.
// Drives sijm_datapath through sijm_pkg::cmd_t and reads sijm_pkg::status_t.
module sijm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  output logic              out_valid,
  input  logic              out_ready,
  input  sijm_pkg::status_t status,
  output sijm_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_STOP,
    S_PREP,
    S_COUNT,
    S_MUL,
    S_CHECK,
    S_ACC,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_MEAN,
    S_DEV_PREP,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_DEV,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_IDLE) && in_valid;
    cmd.clear     = (state == S_CLEAR);
    cmd.set_stop  = (state == S_STOP);
    cmd.prep      = (state == S_PREP);
    cmd.count     = (state == S_COUNT);
    cmd.mul       = (state == S_MUL);
    cmd.check     = (state == S_CHECK);
    cmd.acc       = (state == S_ACC);
    cmd.div_start = (state == S_DIV1_GO) || (state == S_DIV2_GO);
    cmd.mean      = (state == S_MEAN);
    cmd.dev_prep  = (state == S_DEV_PREP);
    cmd.dev       = (state == S_DEV);
    cmd.load_out  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the final step a taken result word is replaced by the new one below.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (func)
              sijm_pkg::FUNC_START:  state <= S_CLEAR;
              sijm_pkg::FUNC_SAMPLE: state <= S_PREP;
              sijm_pkg::FUNC_STOP:   state <= S_STOP;
              default:               state <= S_DONE;
            endcase
          end
        end
        S_CLEAR:  state <= S_DONE;
        S_STOP:   state <= S_DONE;
        S_PREP:   state <= S_COUNT;
        S_COUNT:  state <= S_MUL;
        S_MUL:    state <= S_CHECK;
        S_CHECK:  state <= S_ACC;
        S_ACC: begin
          if (status.phase == sijm_pkg::PH_MEASURE) begin
            state <= S_DIV1_GO;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV1_GO: state <= S_DIV1_WAIT;
        S_DIV1_WAIT: begin
          if (status.div_done) begin
            state <= S_MEAN;
          end
        end
        S_MEAN:     state <= S_DEV_PREP;
        S_DEV_PREP: state <= S_DIV2_GO;
        S_DIV2_GO:  state <= S_DIV2_WAIT;
        S_DIV2_WAIT: begin
          if (status.div_done) begin
            state <= S_DEV;
          end
        end
        S_DEV: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sijm_datapath.sv -----
// Datapath of the jitter monitor: phase, counters, statistics and the result register.
// Uses sijm_pkg types and instantiates sijm_div for the two running-mean divisions.
module sijm_datapath #(
  parameter int FRAC_BITS     = sijm_pkg::FRAC_BITS_DEF,
  parameter int INTERVAL_BITS = sijm_pkg::INTERVAL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sijm_pkg::cmd_t           cmd,
  output sijm_pkg::status_t        status,
  input  logic [63:0]              timestamp,
  input  logic [15:0]              sample_period,
  input  logic [31:0]              settle_time,
  input  logic [31:0]              stop_wait_time,
  output logic                     finished,
  output logic [1:0]               phase,
  output logic [31:0]              measured_count,
  output logic [31:0]              interval,
  output logic [47:0]              mean_interval,
  output logic signed [47:0]       mean_deviation,
  output logic [31:0]              longest,
  output logic [31:0]              shortest
);

  localparam logic [63:0] IV_LIM = (64'd1 << INTERVAL_BITS) - 64'd1;
  localparam logic [63:0] MAX48  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [47:0] DEV_HI = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] DEV_LO = 48'h8000_0000_0000;
  localparam int          NW     = sijm_pkg::DIV_NUM_W;

  sijm_pkg::phase_t phase_reg;
  logic             stop_pending;
  logic [31:0]      settle_count, run_count, stop_count;
  logic [63:0]      last_timestamp;
  logic [31:0]      last_interval;
  logic [47:0]      mean_acc;
  logic [47:0]      deviation_acc;
  logic [31:0]      max_interval, min_interval;

  logic [63:0]      ts_hold;
  logic [31:0]      iv;
  logic [47:0]      prod;
  logic             num_neg;
  logic [NW-1:0]    num_mag;

  logic [63:0]      raw, x_wide;
  logic [31:0]      iv_sat;
  logic [47:0]      x;
  logic [49:0]      diff1;
  logic [50:0]      diff2;
  logic [31:0]      denom;
  logic             div_done;
  logic [NW-1:0]    quot;
  logic [50:0]      q_s;
  logic [51:0]      mean_sum, dev_sum;
  logic [47:0]      mean_new, dev_new;
  logic [31:0]      count_sel;

  function automatic logic [31:0] inc_sat(input logic [31:0] v);
    inc_sat = (v == sijm_pkg::ALL_ONES32) ? v : v + 32'd1;
  endfunction

  always_comb begin
    raw    = ts_hold - last_timestamp;
    iv_sat = (raw > IV_LIM) ? IV_LIM[31:0] : raw[31:0];
    x_wide = {32'd0, iv} << FRAC_BITS;
    x      = (x_wide > MAX48) ? MAX48[47:0] : x_wide[47:0];
    // Numerators are held as sign and magnitude; the divider works on magnitudes.
    diff1  = {2'b00, x} - {2'b00, mean_acc};
    diff2  = {3'b000, mean_acc} - {3'b000, x} - {{3{deviation_acc[47]}}, deviation_acc};
    denom  = (run_count == 32'd0) ? 32'd1 : run_count;
    q_s    = num_neg ? (~{1'b0, quot} + 51'd1) : {1'b0, quot};
    mean_sum = {4'b0000, mean_acc} + {q_s[50], q_s};
    dev_sum  = {{4{deviation_acc[47]}}, deviation_acc} + {q_s[50], q_s};
    if (mean_sum[51]) begin
      mean_new = '0;
    end else if (mean_sum[50:48] != 3'b000) begin
      mean_new = MAX48[47:0];
    end else begin
      mean_new = mean_sum[47:0];
    end
    if (dev_sum[51] && (dev_sum[51:47] != 5'b11111)) begin
      dev_new = DEV_LO;
    end else if (!dev_sum[51] && (dev_sum[51:47] != 5'b00000)) begin
      dev_new = DEV_HI;
    end else begin
      dev_new = dev_sum[47:0];
    end
    count_sel = (phase_reg == sijm_pkg::PH_SETTLE) ? settle_count : stop_count;
  end

  sijm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (num_mag),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  assign status = {phase_reg, div_done};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase_reg      <= rst ? sijm_pkg::PH_IDLE : sijm_pkg::PH_SETTLE;
      stop_pending   <= 1'b0;
      settle_count   <= '0;
      run_count      <= '0;
      stop_count     <= '0;
      last_timestamp <= '0;
      last_interval  <= '0;
      mean_acc       <= '0;
      deviation_acc  <= '0;
      max_interval   <= '0;
      min_interval   <= sijm_pkg::ALL_ONES32;
    end else begin
      if (cmd.set_stop) begin
        stop_pending <= 1'b1;
      end
      if (cmd.prep) begin
        last_timestamp <= ts_hold;
        if (stop_pending && (phase_reg != sijm_pkg::PH_STOP_WAIT)) begin
          phase_reg  <= sijm_pkg::PH_STOP_WAIT;
          stop_count <= '0;
        end
      end
      if (cmd.count) begin
        case (phase_reg)
          sijm_pkg::PH_SETTLE: begin
            run_count    <= '0;
            settle_count <= inc_sat(settle_count);
          end
          sijm_pkg::PH_MEASURE:   run_count  <= inc_sat(run_count);
          sijm_pkg::PH_STOP_WAIT: stop_count <= inc_sat(stop_count);
          default: ;
        endcase
      end
      if (cmd.check) begin
        if ((phase_reg == sijm_pkg::PH_SETTLE) && (prod >= {16'd0, settle_time})) begin
          run_count <= 32'd1;
          phase_reg <= sijm_pkg::PH_MEASURE;
        end else if ((phase_reg == sijm_pkg::PH_STOP_WAIT) &&
                     (prod >= {16'd0, stop_wait_time})) begin
          phase_reg    <= sijm_pkg::PH_IDLE;
          stop_pending <= 1'b0;
        end
      end
      if (cmd.acc && (phase_reg == sijm_pkg::PH_SETTLE)) begin
        mean_acc      <= x;
        deviation_acc <= '0;
      end
      if (cmd.mean) begin
        mean_acc <= mean_new;
      end
      if (cmd.dev) begin
        deviation_acc <= dev_new;
        last_interval <= iv;
        if (iv > max_interval) begin
          max_interval <= iv;
        end
        if (iv < min_interval) begin
          min_interval <= iv;
        end
      end
    end
  end

  // Working registers and the result word carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ts_hold <= timestamp;
    end
    if (cmd.prep) begin
      iv <= iv_sat;
    end
    if (cmd.mul) begin
      prod <= {16'd0, count_sel} * {32'd0, sample_period};
    end
    if (cmd.acc) begin
      num_neg <= diff1[49];
      num_mag <= diff1[49] ? (~diff1 + 50'd1) : diff1;
    end
    if (cmd.dev_prep) begin
      num_neg <= diff2[50];
      num_mag <= diff2[50] ? NW'(~diff2 + 51'd1) : diff2[NW-1:0];
    end
    if (cmd.load_out) begin
      finished       <= (phase_reg == sijm_pkg::PH_IDLE);
      phase          <= phase_reg;
      measured_count <= run_count;
      interval       <= last_interval;
      mean_interval  <= mean_acc;
      mean_deviation <= deviation_acc;
      longest        <= max_interval;
      shortest       <= min_interval;
    end
  end

endmodule

// ----- src/sample_interval_jitter_monitor_core.sv -----
// Sample interval jitter monitor: measures how regular a sampling tick is from its
// timestamps. One word in gives one result word out. A start or stop word passes its clear
// or stop step before its result, an unused code goes straight to it; a sample word passes
// prepare, count, multiply, check and accumulate, and in the measure phase also the two
// running-mean divisions by the measured count, done in the shared divider at two quotient
// bits a cycle. The next word can be accepted in the same cycle as a result is presented.
// Words are taken one at a time; a finished result waits in the output register while the
// next word is accepted. Registers sit at byte addresses 0, 4 and 8 of the APB port.
// Top level; depends on sijm_pkg, sijm_ctrl, sijm_datapath and sijm_div.
module sample_interval_jitter_monitor_core #(
  parameter int FRAC_BITS     = sijm_pkg::FRAC_BITS_DEF,
  parameter int INTERVAL_BITS = sijm_pkg::INTERVAL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [63:0]        timestamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               finished,
  output logic [1:0]         phase,
  output logic [31:0]        measured_count,
  output logic [31:0]        interval,
  output logic [47:0]        mean_interval,
  output logic signed [47:0] mean_deviation,
  output logic [31:0]        longest,
  output logic [31:0]        shortest
);

  logic [15:0]       sample_period;
  logic [31:0]       settle_time;
  logic [31:0]       stop_wait_time;
  logic [1:0]        reg_index;
  logic              wr_en;
  sijm_pkg::cmd_t    cmd;
  sijm_pkg::status_t status;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period  <= sijm_pkg::RESET_SAMPLE_PERIOD;
      settle_time    <= sijm_pkg::RESET_SETTLE_TIME;
      stop_wait_time <= sijm_pkg::RESET_STOP_TIME;
    end else if (wr_en) begin
      case (reg_index)
        sijm_pkg::REG_SAMPLE_PERIOD: sample_period  <= pwdata[15:0];
        sijm_pkg::REG_SETTLE_TIME:   settle_time    <= pwdata;
        sijm_pkg::REG_STOP_TIME:     stop_wait_time <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      sijm_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, sample_period};
      sijm_pkg::REG_SETTLE_TIME:   prdata = settle_time;
      sijm_pkg::REG_STOP_TIME:     prdata = stop_wait_time;
      default:                     prdata = '0;
    endcase
  end

  sijm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sijm_datapath #(
    .FRAC_BITS     (FRAC_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .timestamp      (timestamp),
    .sample_period  (sample_period),
    .settle_time    (settle_time),
    .stop_wait_time (stop_wait_time),
    .finished       (finished),
    .phase          (phase),
    .measured_count (measured_count),
    .interval       (interval),
    .mean_interval  (mean_interval),
    .mean_deviation (mean_deviation),
    .longest        (longest),
    .shortest       (shortest)
  );

endmodule

// ----- src/sijm_checker.sv -----
// Port-level checks for the jitter monitor, bound to the top level.
// Depends on sijm_pkg for the phase codes and on the top level's port names.
module sijm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        finished,
  input logic [1:0]  phase,
  input logic [31:0] measured_count,
  input logic [31:0] longest,
  input logic [31:0] shortest
);

  // A result word waiting for the sink must not change under it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(measured_count))
    else $error("result word changed while stalled");

  // Words are worked one at a time, so the port closes right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (finished == (phase == sijm_pkg::PH_IDLE)))
    else $error("finished flag disagrees with phase");

  // Nothing is counted while settling.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == sijm_pkg::PH_SETTLE) |-> (measured_count == 32'd0))
    else $error("measured count non-zero in settle phase");

  // Once a shortest interval is recorded, the longest cannot be below it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (shortest != sijm_pkg::ALL_ONES32) |-> (longest >= shortest))
    else $error("longest interval below shortest");

endmodule

bind sample_interval_jitter_monitor_core sijm_checker u_checker (.*);

// ----- tb/sv/sample_interval_jitter_monitor_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sample interval jitter monitor: follows register writes on the APB port,
// predicts every result word from the accepted input words and compares field by field.
// Depends on sijm_pkg for the item, phase and register codes.
module sample_interval_jitter_monitor_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         func,
  input  logic [63:0]        timestamp,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               finished,
  input  logic [1:0]         phase,
  input  logic [31:0]        measured_count,
  input  logic [31:0]        interval,
  input  logic [47:0]        mean_interval,
  input  logic signed [47:0] mean_deviation,
  input  logic [31:0]        longest,
  input  logic [31:0]        shortest,
  output int                 mismatches,
  output int                 pending
);

  localparam int          FRAC      = sijm_pkg::FRAC_BITS_DEF;
  localparam logic [47:0] MEAN_MAX  = '1;
  localparam longint      DEV_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      DEV_MIN   = -DEV_MAX - 1;

  typedef struct packed {
    logic               finished;
    sijm_pkg::phase_t   phase;
    logic [31:0]        count;
    logic [31:0]        interval;
    logic [47:0]        mean;
    logic signed [47:0] dev;
    logic [31:0]        longest;
    logic [31:0]        shortest;
  } stats_t;

  stats_t pending_stats[$];

  // Register copies.
  logic [15:0] period;
  logic [31:0] settle_time;
  logic [31:0] stop_time;

  // Predicted monitor state.
  sijm_pkg::phase_t   ph;
  logic               stop_pending;
  logic [31:0]        settle_cnt;
  logic [31:0]        run_cnt;
  logic [31:0]        stop_cnt;
  logic [63:0]        last_ts;
  logic [31:0]        last_iv;
  logic [47:0]        mean_acc;
  logic signed [47:0] dev_acc;
  logic [31:0]        max_iv;
  logic [31:0]        min_iv;

  function automatic void clear_stats();
    ph           = sijm_pkg::PH_IDLE;
    stop_pending = 1'b0;
    settle_cnt   = '0;
    run_cnt      = '0;
    stop_cnt     = '0;
    last_ts      = '0;
    last_iv      = '0;
    mean_acc     = '0;
    dev_acc      = '0;
    max_iv       = '0;
    min_iv       = sijm_pkg::ALL_ONES32;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] cnt);
    return (cnt == sijm_pkg::ALL_ONES32) ? cnt : cnt + 32'd1;
  endfunction

  function automatic logic time_reached(logic [31:0] cnt, logic [31:0] limit);
    logic [63:0] prod;
    prod = {32'b0, cnt} * {48'b0, period};
    return prod >= {32'b0, limit};
  endfunction

  // Running mean and running mean of (mean - interval), both divided by the run count
  // with truncation towards zero.
  function automatic void fold_interval(logic [31:0] iv);
    longint      n;
    longint      x;
    longint      m;
    longint      d;
    longint      dv;
    logic [63:0] xu;
    n  = run_cnt;
    if (n < 1) n = 1;
    xu = {32'b0, iv} << FRAC;
    if (xu > {16'b0, MEAN_MAX}) xu = {16'b0, MEAN_MAX};
    x  = xu;
    m  = mean_acc;
    m  = m + (x - m) / n;
    if (m < 0) m = 0;
    if (m > {16'b0, MEAN_MAX}) m = {16'b0, MEAN_MAX};
    mean_acc = m[47:0];
    d  = m - x;
    dv = dev_acc;
    dv = dv + (d - dv) / n;
    if (dv > DEV_MAX) dv = DEV_MAX;
    if (dv < DEV_MIN) dv = DEV_MIN;
    dev_acc = dv[47:0];
    last_iv = iv;
    if (iv > max_iv) max_iv = iv;
    if (iv < min_iv) min_iv = iv;
  endfunction

  function automatic void take_tick(logic [63:0] ts);
    logic [63:0] raw;
    logic [31:0] iv;
    logic [63:0] xu;
    raw     = ts - last_ts;
    iv      = (raw > {32'b0, sijm_pkg::ALL_ONES32}) ? sijm_pkg::ALL_ONES32 : raw[31:0];
    last_ts = ts;
    if (stop_pending && ph != sijm_pkg::PH_STOP_WAIT) begin
      ph       = sijm_pkg::PH_STOP_WAIT;
      stop_cnt = '0;
    end
    case (ph)
      sijm_pkg::PH_SETTLE: begin
        run_cnt    = '0;
        settle_cnt = bump(settle_cnt);
        if (time_reached(settle_cnt, settle_time)) begin
          run_cnt = 32'd1;
          ph      = sijm_pkg::PH_MEASURE;
        end
      end
      sijm_pkg::PH_MEASURE: begin
        run_cnt = bump(run_cnt);
      end
      sijm_pkg::PH_STOP_WAIT: begin
        stop_cnt = bump(stop_cnt);
        if (time_reached(stop_cnt, stop_time)) begin
          ph           = sijm_pkg::PH_IDLE;
          stop_pending = 1'b0;
        end
      end
      default: ;
    endcase
    if (ph == sijm_pkg::PH_SETTLE) begin
      xu       = {32'b0, iv} << FRAC;
      mean_acc = (xu > {16'b0, MEAN_MAX}) ? MEAN_MAX : xu[47:0];
      dev_acc  = '0;
    end else if (ph == sijm_pkg::PH_MEASURE) begin
      fold_interval(iv);
    end
  endfunction

  function automatic stats_t step_jitter_stats(logic [1:0] f, logic [63:0] ts);
    stats_t s;
    case (f)
      sijm_pkg::FUNC_START: begin
        clear_stats();
        ph = sijm_pkg::PH_SETTLE;
      end
      sijm_pkg::FUNC_SAMPLE: take_tick(ts);
      sijm_pkg::FUNC_STOP:   stop_pending = 1'b1;
      default: ;
    endcase
    s.finished = (ph == sijm_pkg::PH_IDLE);
    s.phase    = ph;
    s.count    = run_cnt;
    s.interval = last_iv;
    s.mean     = mean_acc;
    s.dev      = dev_acc;
    s.longest  = max_iv;
    s.shortest = min_iv;
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    stats_t got;
    stats_t want;
    if (rst) begin
      period      = sijm_pkg::RESET_SAMPLE_PERIOD;
      settle_time = sijm_pkg::RESET_SETTLE_TIME;
      stop_time   = sijm_pkg::RESET_STOP_TIME;
      clear_stats();
      pending_stats.delete();
      mismatches  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          sijm_pkg::REG_SAMPLE_PERIOD: period      = pwdata[15:0];
          sijm_pkg::REG_SETTLE_TIME:   settle_time = pwdata;
          sijm_pkg::REG_STOP_TIME:     stop_time   = pwdata;
          default: ;
        endcase
      end
      // Results are taken before inputs: a word accepted at this edge cannot have
      // produced the result leaving at the same edge.
      if (out_valid && out_ready) begin
        got.finished = finished;
        got.phase    = sijm_pkg::phase_t'(phase);
        got.count    = measured_count;
        got.interval = interval;
        got.mean     = mean_interval;
        got.dev      = mean_deviation;
        got.longest  = longest;
        got.shortest = shortest;
        if (pending_stats.size() == 0) begin
          $display("%0t: result word with none outstanding, got %h", $time, got);
          mismatches++;
        end else begin
          want = pending_stats.pop_front();
          check_field("finished", want.finished, got.finished);
          check_field("phase", want.phase, got.phase);
          check_field("measured_count", want.count, got.count);
          check_field("interval", want.interval, got.interval);
          check_field("mean_interval", want.mean, got.mean);
          check_field("mean_deviation", want.dev, got.dev);
          check_field("longest", want.longest, got.longest);
          check_field("shortest", want.shortest, got.shortest);
        end
      end
      if (in_valid && in_ready) pending_stats.push_back(step_jitter_stats(func, timestamp));
    end
    pending <= pending_stats.size();
  end

endmodule

// ----- tb/sv/sample_interval_jitter_monitor_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the jitter monitor testbench: clock, reset, register writes, input words and
// output back-pressure, with the verdict. Depends on sijm_pkg, the core and its checker.
module sample_interval_jitter_monitor_core_tb;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET  = 1300;
  localparam int         LIMIT_CYCLES = 2_000_000;
  localparam int         LONG_HOLD    = 500;
  localparam int         SETTLE_SLACK = 80;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [3:0]         paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         func      = sijm_pkg::FUNC_START;
  logic [63:0]        timestamp = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               finished;
  logic [1:0]         phase;
  logic [31:0]        measured_count;
  logic [31:0]        interval;
  logic [47:0]        mean_interval;
  logic signed [47:0] mean_deviation;
  logic [31:0]        longest;
  logic [31:0]        shortest;
  int                 mismatches;
  int                 pending;

  logic [63:0] now_ts     = '0;
  int          words_sent = 0;
  logic        steady     = 1'b0;

  sample_interval_jitter_monitor_core dut (.*);

  sample_interval_jitter_monitor_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [31:0] pick_time(logic [15:0] per);
    logic [63:0] t;
    int          r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return sijm_pkg::ALL_ONES32;
    if (r == 2) return $urandom_range(1, 100);
    t = {48'b0, per} * $urandom_range(1, 6);
    if (per != 0) t = t - $urandom_range(0, per - 1);
    return t[31:0];
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] per, input logic [31:0] settle,
                            input logic [31:0] stop_wait);
    write_reg(sijm_pkg::REG_SAMPLE_PERIOD, {16'b0, per});
    write_reg(sijm_pkg::REG_SETTLE_TIME, settle);
    write_reg(sijm_pkg::REG_STOP_TIME, stop_wait);
  endtask

  // Valid is only lowered when a gap follows, so a back-to-back word never sees valid
  // dropped and raised within one step.
  task automatic send_word(input logic [1:0] f, input logic [63:0] ts);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    timestamp <= ts;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_SLACK) @(posedge clk);
  endtask

  // One measurement run: start, regular ticks with jitter, a stop somewhere in the
  // second half (or none), and a sprinkling of stray words.
  task automatic run_session(input logic [63:0] nominal, input int jitter, input int span);
    int          stop_at;
    int          k;
    logic [63:0] advance;
    stop_at = $urandom_range(span / 2, span);
    if ($urandom_range(0, 3) == 0) now_ts = {$urandom, $urandom};
    send_word(sijm_pkg::FUNC_START, {$urandom, $urandom});
    for (k = 0; k < span; k++) begin
      if (k == stop_at) send_word(sijm_pkg::FUNC_STOP, {$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), {$urandom, $urandom});
      end else begin
        advance = nominal + $urandom_range(0, 2 * jitter) - jitter;
        now_ts  = now_ts + advance;
        send_word(sijm_pkg::FUNC_SAMPLE, now_ts);
      end
    end
  endtask

  initial begin : receiver
    int stall;
    int taken;
    stall = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 200 || taken == 900) stall = LONG_HOLD;
        else if ((taken / 64) % 4 != 3) stall = pick_gap();
      end
      if (rst || stall > 0) begin
        out_ready <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int          phase_no;
    int          r;
    logic [15:0] per;
    logic [63:0] nominal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short settle and stop wait so that every phase is reached in a few words.
    set_config(16'd1, 32'd2, 32'd2);
    send_word(FUNC_UNUSED, '1);
    send_word(sijm_pkg::FUNC_STOP, '0);            // stop while idle
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd100);     // runs a stop wait from idle
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd50);      // backwards step saturates, back to idle
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd70);
    send_word(sijm_pkg::FUNC_START, '1);
    send_word(sijm_pkg::FUNC_SAMPLE, '0);          // settle with a zero interval
    send_word(sijm_pkg::FUNC_SAMPLE, '1);          // saturated interval, enters measure
    send_word(sijm_pkg::FUNC_SAMPLE, '0);          // timestamp wraps round
    send_word(sijm_pkg::FUNC_SAMPLE, '0);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd1000);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'h0000_0001_0000_03E8);
    send_word(FUNC_UNUSED, '0);
    send_word(sijm_pkg::FUNC_STOP, '0);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'h0000_0001_0000_0400);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'h0000_0001_0000_0500);
    wait_drained();

    // A zero period ends a phase at once only when its time is zero.
    set_config('0, '0, '0);
    send_word(sijm_pkg::FUNC_START, '0);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd10);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd25);
    send_word(sijm_pkg::FUNC_STOP, '0);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd40);
    wait_drained();
    set_config('0, 32'd5, sijm_pkg::ALL_ONES32);
    send_word(sijm_pkg::FUNC_START, '0);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd7);
    send_word(sijm_pkg::FUNC_SAMPLE, 64'd9);

    phase_no = 0;
    while (words_sent < ITEM_TARGET) begin
      wait_drained();
      case (phase_no % 8)
        0:       per = 16'd1;
        1:       per = '0;
        2:       per = '1;
        default: per = $urandom_range(1, 3000);
      endcase
      set_config(per, pick_time(per), pick_time(per));
      steady = (phase_no % 5 == 3);
      r = $urandom_range(0, 9);
      if (r == 0) nominal = '0;
      else if (r == 1) nominal = {30'b0, 2'($urandom_range(1, 3)), $urandom};
      else if (r == 2) nominal = {$urandom, $urandom};
      else nominal = $urandom_range(1, 5000);
      run_session(nominal, $urandom_range(0, 40), $urandom_range(8, 40));
      phase_no++;
    end

    wait_drained();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sample_interval_jitter_monitor_core.f -----
src/sijm_pkg.sv
src/sijm_div.sv
src/sijm_ctrl.sv
src/sijm_datapath.sv
src/sample_interval_jitter_monitor_core.sv
src/sijm_checker.sv
tb/sv/sample_interval_jitter_monitor_checker.sv
tb/sv/sample_interval_jitter_monitor_core_tb.sv
